// File: src/pip_pkg.sv
package pip_pkg;

    localparam int VCOUNT_W      = 7;
    localparam int INDEX_W       = 6;
    localparam int RAY_FAR_RESET = 10000;

    localparam logic [0:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [0:0] CFG_RAY_FAR_X    = 1'b1;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OR_COL,
        OR_CW,
        OR_CCW
    } t_orient;

    typedef struct packed {
        logic valid;
        logic crossed;
        logic coll;
        logic on_box;
    } t_edge_res;

    function automatic t_orient f_orient(input logic is_zero, input logic is_neg);
        t_orient o;
        if (is_zero) begin
            o = OR_COL;
        end else if (is_neg) begin
            o = OR_CCW;
        end else begin
            o = OR_CW;
        end
        return o;
    endfunction

endpackage

// File: src/pip_vmem.sv
module pip_vmem
    import pip_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int W     = 15
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic signed [W-1:0]      i_wx,
    input  logic signed [W-1:0]      i_wy,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic signed [W-1:0]      o_rx,
    output logic signed [W-1:0]      o_ry
);

    logic [2*W-1:0] mem [DEPTH];
    logic [2*W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wx, i_wy};
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rx = $signed(r_rdata[2*W-1:W]);
    assign o_ry = $signed(r_rdata[W-1:0]);

endmodule

// File: src/pip_edge.sv
module pip_edge
    import pip_pkg::*;
#(
    parameter int W = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_ax,
    input  logic signed [W-1:0] i_ay,
    input  logic signed [W-1:0] i_bx,
    input  logic signed [W-1:0] i_by,
    input  logic signed [W-1:0] i_px,
    input  logic signed [W-1:0] i_py,
    input  logic signed [W-1:0] i_fx,
    output t_edge_res           o_res
);

    localparam int PW = 2 * W + 2;

    // stage 1: differences, box tests, ray-side orientations
    logic              r_v1;
    logic signed [W:0] r_dyab, r_dxab, r_dxpb, r_dypb, r_dxfb;
    logic              r_p_in_ab1, r_f_in_ab1, r_a_in_pf1, r_b_in_pf1;
    t_orient           r_o3_1, r_o4_1;

    // stage 2: products
    logic              r_v2;
    logic signed [PW-1:0] r_m1, r_m2, r_m3;
    logic              r_p_in_ab2, r_f_in_ab2, r_a_in_pf2, r_b_in_pf2;
    t_orient           r_o3_2, r_o4_2;

    logic p_in_ab, f_in_ab, a_in_pf, b_in_pf;
    logic signed [PW:0] v1, v2;
    t_orient o1, o2;
    logic crossed;

    always_comb begin
        p_in_ab = ((i_px >= i_ax && i_px <= i_bx) || (i_px >= i_bx && i_px <= i_ax))
               && ((i_py >= i_ay && i_py <= i_by) || (i_py >= i_by && i_py <= i_ay));
        f_in_ab = ((i_fx >= i_ax && i_fx <= i_bx) || (i_fx >= i_bx && i_fx <= i_ax))
               && ((i_py >= i_ay && i_py <= i_by) || (i_py >= i_by && i_py <= i_ay));
        a_in_pf = ((i_ax >= i_px && i_ax <= i_fx) || (i_ax >= i_fx && i_ax <= i_px))
               && (i_ay == i_py);
        b_in_pf = ((i_bx >= i_px && i_bx <= i_fx) || (i_bx >= i_fx && i_bx <= i_px))
               && (i_by == i_py);
    end

    always_ff @(posedge i_clk) begin
        r_dyab     <= $signed({i_by[W-1], i_by}) - $signed({i_ay[W-1], i_ay});
        r_dxab     <= $signed({i_bx[W-1], i_bx}) - $signed({i_ax[W-1], i_ax});
        r_dxpb     <= $signed({i_px[W-1], i_px}) - $signed({i_bx[W-1], i_bx});
        r_dypb     <= $signed({i_py[W-1], i_py}) - $signed({i_by[W-1], i_by});
        r_dxfb     <= $signed({i_fx[W-1], i_fx}) - $signed({i_bx[W-1], i_bx});
        r_p_in_ab1 <= p_in_ab;
        r_f_in_ab1 <= f_in_ab;
        r_a_in_pf1 <= a_in_pf;
        r_b_in_pf1 <= b_in_pf;
        // ray is horizontal: sign is -(fx-px)*(vy-py)
        r_o3_1     <= f_orient((i_fx == i_px) || (i_ay == i_py),
                               (i_fx > i_px) == (i_ay > i_py));
        r_o4_1     <= f_orient((i_fx == i_px) || (i_by == i_py),
                               (i_fx > i_px) == (i_by > i_py));

        r_m1       <= $signed({{(W+1){r_dyab[W]}}, r_dyab})
                    * $signed({{(W+1){r_dxpb[W]}}, r_dxpb});
        r_m2       <= $signed({{(W+1){r_dxab[W]}}, r_dxab})
                    * $signed({{(W+1){r_dypb[W]}}, r_dypb});
        r_m3       <= $signed({{(W+1){r_dyab[W]}}, r_dyab})
                    * $signed({{(W+1){r_dxfb[W]}}, r_dxfb});
        r_p_in_ab2 <= r_p_in_ab1;
        r_f_in_ab2 <= r_f_in_ab1;
        r_a_in_pf2 <= r_a_in_pf1;
        r_b_in_pf2 <= r_b_in_pf1;
        r_o3_2     <= r_o3_1;
        r_o4_2     <= r_o4_1;
    end

    always_comb begin
        v1 = $signed({r_m1[PW-1], r_m1}) - $signed({r_m2[PW-1], r_m2});
        v2 = $signed({r_m3[PW-1], r_m3}) - $signed({r_m2[PW-1], r_m2});
        o1 = f_orient(v1 == '0, v1[PW]);
        o2 = f_orient(v2 == '0, v2[PW]);
        crossed = (o1 != o2 && r_o3_2 != r_o4_2)
               || (o1 == OR_COL && r_p_in_ab2)
               || (o2 == OR_COL && r_f_in_ab2)
               || (r_o3_2 == OR_COL && r_a_in_pf2)
               || (r_o4_2 == OR_COL && r_b_in_pf2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_res.valid <= 1'b0;
        end else begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            o_res.valid <= r_v2;
        end
        o_res.crossed <= crossed;
        o_res.coll    <= (o1 == OR_COL);
        o_res.on_box  <= r_p_in_ab2;
    end

endmodule

// File: src/point_in_polygon_test.sv
// Point-in-polygon test by ray casting over a stored polygon.
// Input channel (i_in_valid / o_in_stall): i_kind selects a load item, which
// writes i_coord_x/i_coord_y into vertex slot i_vertex_index, or a query
// item, which tests the point i_coord_x/i_coord_y. Slots at or above
// MAX_VERTICES are ignored.
// Output channel (o_out_valid / i_out_stall): one item per query, none per
// load: o_inside_res (inside or on boundary) and o_degenerate (fewer than
// three vertices in use).
// Config port: i_cfg_we writes vertex_count (index 0) or ray_far_x (index 1).
// Throughput: a load leaves the input free for the next item. A query walks
// the vertex memory one vertex per cycle through its single read port, n+1
// reads for n vertices, then a three-stage edge test pipeline; the input
// stalls from its acceptance until its result is handed to the output
// register. A degenerate query skips the walk and goes straight to finish.
// A finished result sits in the output register; the next item is accepted
// meanwhile, and a following query waits at its end until that register
// is taken.
// Reset clears the control state and registers (vertex_count 0, ray_far_x
// 10000); the vertex memory is not cleared and must be loaded before use.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [0:0]                    i_cfg_addr,
    input  logic [COORD_WIDTH-1:0]        i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [INDEX_W-1:0]            i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_inside_res,
    output logic                          o_degenerate
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int W  = COORD_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state                r_state;
    logic [VCOUNT_W-1:0]   r_vcount;
    logic signed [W-1:0]   r_far_x;
    logic [CW-1:0]         r_n, r_step, r_left;
    logic                  r_rd_vld, r_rd_first;
    logic                  r_hit, r_hit_val, r_par, r_degen;
    logic signed [W-1:0]   r_px, r_py, r_prev_x, r_prev_y;

    logic                  in_acc, out_free;
    logic [CW-1:0]         n_count;
    logic                  mem_we, mem_re;
    logic [AW-1:0]         mem_raddr;
    logic signed [W-1:0]   rd_x, rd_y;
    t_edge_res             edge_res;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !o_out_valid || !i_out_stall;

    always_comb begin
        if (32'(r_vcount) > 32'(MAX_VERTICES)) begin
            n_count = CW'(MAX_VERTICES);
        end else begin
            n_count = CW'(r_vcount);
        end
    end

    assign mem_we    = in_acc && (i_kind == KIND_LOAD)
                    && (32'(i_vertex_index) < 32'(MAX_VERTICES));
    assign mem_re    = (r_state == S_WALK);
    assign mem_raddr = (r_step == r_n) ? '0 : AW'(r_step);

    pip_vmem #(
        .DEPTH (MAX_VERTICES),
        .W     (W)
    ) u_vmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_vertex_index)),
        .i_wx    (i_coord_x),
        .i_wy    (i_coord_y),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rx    (rd_x),
        .o_ry    (rd_y)
    );

    pip_edge #(
        .W (W)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_vld && !r_rd_first),
        .i_ax    (r_prev_x),
        .i_ay    (r_prev_y),
        .i_bx    (rd_x),
        .i_by    (rd_y),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_fx    (r_far_x),
        .o_res   (edge_res)
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
        if (r_rd_vld) begin
            r_prev_x <= rd_x;
            r_prev_y <= rd_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vcount     <= '0;
            r_far_x      <= W'(RAY_FAR_RESET);
            r_n          <= '0;
            r_step       <= '0;
            r_left       <= '0;
            r_rd_vld     <= 1'b0;
            r_rd_first   <= 1'b0;
            r_hit        <= 1'b0;
            r_hit_val    <= 1'b0;
            r_par        <= 1'b0;
            r_degen      <= 1'b0;
            o_out_valid  <= 1'b0;
            o_inside_res <= 1'b0;
            o_degenerate <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_VERTEX_COUNT: r_vcount <= i_cfg_wdata[VCOUNT_W-1:0];
                    CFG_RAY_FAR_X:    r_far_x  <= $signed(i_cfg_wdata);
                    default: ;
                endcase
            end

            if (o_out_valid && !i_out_stall && r_state != S_FINISH) begin
                o_out_valid <= 1'b0;
            end

            r_rd_vld   <= mem_re;
            r_rd_first <= mem_re && (r_step == '0);

            if (edge_res.valid) begin
                r_left <= r_left - CW'(1);
                if (edge_res.crossed && !r_hit) begin
                    if (edge_res.coll) begin
                        r_hit     <= 1'b1;
                        r_hit_val <= edge_res.on_box;
                    end else begin
                        r_par <= ~r_par;
                    end
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_kind == KIND_QUERY) begin
                        r_n       <= n_count;
                        r_left    <= n_count;
                        r_step    <= '0;
                        r_hit     <= 1'b0;
                        r_hit_val <= 1'b0;
                        r_par     <= 1'b0;
                        if (n_count < CW'(3)) begin
                            r_degen <= 1'b1;
                            r_state <= S_FINISH;
                        end else begin
                            r_degen <= 1'b0;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    r_step <= r_step + CW'(1);
                    if (r_step == r_n) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (edge_res.valid && r_left == CW'(1)) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (out_free) begin
                        o_out_valid  <= 1'b1;
                        o_inside_res <= r_hit ? r_hit_val : r_par;
                        o_degenerate <= r_degen;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_edge_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_res.valid |-> (r_state == S_WALK || r_state == S_DRAIN))
        else $error("edge result outside a query walk");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_step <= r_n))
        else $error("walk step beyond vertex count");

    a_read_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_WALK || r_state == S_DRAIN))
        else $error("memory read data outside a query walk");

    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !r_degen) |-> (r_left == '0 && !edge_res.valid))
        else $error("query finished with edges in flight");

    a_no_load_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !mem_re)
        else $error("vertex write during a walk");
`endif

endmodule

// File: sim/tb_point_in_polygon_test.sv
`timescale 1ns / 100ps

module tb_point_in_polygon_test;
    import pip_pkg::*;

    localparam int MAX_VERT = 64;
    localparam int COORD_W  = 15;
    localparam int ITEMS    = 1200;
    localparam int SETTLE   = 80;
    localparam int LIMIT    = 4000;
    localparam int C_MIN    = -16384;
    localparam int C_MAX    = 16383;

    typedef struct packed {
        logic in_poly;
        logic degen;
    } t_verdict;

    class polygon_tracker;
        logic signed [COORD_W-1:0] vx [MAX_VERT];
        logic signed [COORD_W-1:0] vy [MAX_VERT];
        logic [VCOUNT_W-1:0]       vcount;
        logic signed [COORD_W-1:0] far_x;
        t_verdict                  verdicts [$];
        int                        mismatches;

        function new();
            vcount     = '0;
            far_x      = COORD_W'(RAY_FAR_RESET);
            mismatches = 0;
        endfunction

        function void set_reg(input logic [0:0] addr, input logic [COORD_W-1:0] data);
            if (addr == CFG_VERTEX_COUNT) begin
                vcount = data[VCOUNT_W-1:0];
            end else begin
                far_x = data;
            end
        endfunction

        function t_orient turn(input longint ax, ay, bx, by, cx, cy);
            longint v;
            v = (by - ay) * (cx - bx) - (bx - ax) * (cy - by);
            if (v == 0) begin
                return OR_COL;
            end
            return (v > 0) ? OR_CW : OR_CCW;
        endfunction

        function bit in_box(input longint ax, ay, qx, qy, cx, cy);
            return qx <= ((ax > cx) ? ax : cx) && qx >= ((ax < cx) ? ax : cx) &&
                   qy <= ((ay > cy) ? ay : cy) && qy >= ((ay < cy) ? ay : cy);
        endfunction

        function bit seg_cross(input longint ax, ay, bx, by, cx, cy, dx, dy);
            t_orient o1, o2, o3, o4;
            o1 = turn(ax, ay, bx, by, cx, cy);
            o2 = turn(ax, ay, bx, by, dx, dy);
            o3 = turn(cx, cy, dx, dy, ax, ay);
            o4 = turn(cx, cy, dx, dy, bx, by);
            if (o1 != o2 && o3 != o4) return 1'b1;
            if (o1 == OR_COL && in_box(ax, ay, cx, cy, bx, by)) return 1'b1;
            if (o2 == OR_COL && in_box(ax, ay, dx, dy, bx, by)) return 1'b1;
            if (o3 == OR_COL && in_box(cx, cy, ax, ay, dx, dy)) return 1'b1;
            if (o4 == OR_COL && in_box(cx, cy, bx, by, dx, dy)) return 1'b1;
            return 1'b0;
        endfunction

        function t_verdict classify(input longint px, py);
            int     n, cnt, j;
            longint ax, ay, bx, by;
            t_verdict r;
            n   = (vcount > MAX_VERT) ? MAX_VERT : int'(vcount);
            cnt = 0;
            r   = '{in_poly: 1'b0, degen: 1'b0};
            if (n < 3) begin
                r.degen = 1'b1;
                return r;
            end
            for (int i = 0; i < n; i++) begin
                j  = (i + 1 == n) ? 0 : i + 1;
                ax = vx[i];
                ay = vy[i];
                bx = vx[j];
                by = vy[j];
                if (seg_cross(ax, ay, bx, by, px, py, longint'(far_x), py)) begin
                    // edge collinear with the point decides at once
                    if (turn(ax, ay, px, py, bx, by) == OR_COL) begin
                        r.in_poly = in_box(ax, ay, px, py, bx, by);
                        return r;
                    end
                    cnt++;
                end
            end
            r.in_poly = cnt[0];
            return r;
        endfunction

        function void note_item(input logic kind, input logic [INDEX_W-1:0] idx,
                                input logic signed [COORD_W-1:0] cx, cy);
            if (kind == KIND_LOAD) begin
                vx[idx] = cx;
                vy[idx] = cy;
            end else begin
                verdicts.insert(verdicts.size(), classify(cx, cy));
            end
        endfunction

        function void check_result(input logic in_poly, input logic degen);
            t_verdict e;
            if (verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected item: inside %0b degenerate %0b", in_poly, degen);
                end
                return;
            end
            e = verdicts.pop_front();
            if (in_poly !== e.in_poly || degen !== e.degen) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t: inside exp %0b got %0b, degenerate exp %0b got %0b",
                             $realtime, e.in_poly, in_poly, e.degen, degen);
                end
            end
        endfunction
    endclass

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_we = 1'b0;
    logic [0:0]                  i_cfg_addr = CFG_VERTEX_COUNT;
    logic [COORD_W-1:0]          i_cfg_wdata = '0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic                        i_kind = KIND_LOAD;
    logic [INDEX_W-1:0]          i_vertex_index = '0;
    logic signed [COORD_W-1:0]   i_coord_x = '0;
    logic signed [COORD_W-1:0]   i_coord_y = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic                        o_inside_res;
    logic                        o_degenerate;

    polygon_tracker tracker = new();
    bit             idling = 1'b1;
    int             stall_left = 0;
    int             quiet = 0;
    int             items_sent = 0;
    int             poly_x [MAX_VERT];
    int             poly_y [MAX_VERT];

    point_in_polygon_test DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_inside_res   (o_inside_res),
        .o_degenerate   (o_degenerate)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_inside_res, o_degenerate);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!idling) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = $urandom_range(0, 18);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic int rnd(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clip(input int v);
        return (v < C_MIN) ? C_MIN : ((v > C_MAX) ? C_MAX : v);
    endfunction

    task automatic push_item(input logic kind, input int idx, input int x, input int y);
        int gap;
        gap = 0;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_vertex_index <= idx[INDEX_W-1:0];
        i_coord_x      <= x[COORD_W-1:0];
        i_coord_y      <= y[COORD_W-1:0];
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_item(kind, idx[INDEX_W-1:0], x[COORD_W-1:0], y[COORD_W-1:0]);
        items_sent++;
    endtask

    task automatic write_reg(input logic [0:0] addr, input int data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data[COORD_W-1:0];
        tracker.set_reg(addr, data[COORD_W-1:0]);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // registers change only with the block drained
    task automatic program_regs(input int count, input int far);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        write_reg(CFG_VERTEX_COUNT, count);
        write_reg(CFG_RAY_FAR_X, far);
    endtask

    task automatic make_polygon(input int nv);
        int  style, cx, cy, rad, rr;
        real ang;
        style = $urandom_range(0, 3);
        cx    = rnd(-12000, 12000);
        cy    = rnd(-12000, 12000);
        rad   = (style == 1) ? rnd(3, 40) : rnd(200, 16000);
        for (int k = 0; k < nv; k++) begin
            if (style == 0) begin
                poly_x[k] = rnd(-6, 6);
                poly_y[k] = rnd(-6, 6);
            end else if (style == 3) begin
                poly_x[k] = rnd(C_MIN, C_MAX);
                poly_y[k] = rnd(C_MIN, C_MAX);
            end else begin
                ang = 6.283185307 * (k + $urandom_range(0, 60) / 100.0) / nv;
                rr  = rad * rnd(50, 100) / 100;
                poly_x[k] = clip(cx + $rtoi(rr * $cos(ang)));
                poly_y[k] = clip(cy + $rtoi(rr * $sin(ang)));
            end
        end
    endtask

    task automatic pick_point(input int nv, output int x, output int y);
        int k, j, xlo, xhi, ylo, yhi;
        xlo = poly_x[0];
        xhi = poly_x[0];
        ylo = poly_y[0];
        yhi = poly_y[0];
        for (int i = 1; i < nv; i++) begin
            xlo = (poly_x[i] < xlo) ? poly_x[i] : xlo;
            xhi = (poly_x[i] > xhi) ? poly_x[i] : xhi;
            ylo = (poly_y[i] < ylo) ? poly_y[i] : ylo;
            yhi = (poly_y[i] > yhi) ? poly_y[i] : yhi;
        end
        k = rnd(0, nv - 1);
        j = (k + 1 == nv) ? 0 : k + 1;
        case ($urandom_range(0, 9))
            0, 1: begin
                x = poly_x[k];
                y = poly_y[k];
            end
            2, 3: begin
                x = (poly_x[k] + poly_x[j]) >>> 1;
                y = (poly_y[k] + poly_y[j]) >>> 1;
            end
            4: begin
                x = rnd(xlo - 2, xhi + 2);
                y = poly_y[k];
            end
            5: begin
                x = rnd(C_MIN, C_MAX);
                y = rnd(C_MIN, C_MAX);
            end
            default: begin
                x = rnd(xlo - 2, xhi + 2);
                y = rnd(ylo - 2, yhi + 2);
            end
        endcase
        x = clip(x);
        y = clip(y);
    endtask

    initial begin
        int count, nv, far, nq, k, x, y, phase;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: no vertices in use
        push_item(KIND_QUERY, 0, 5, 5);
        push_item(KIND_LOAD, 0, C_MIN, C_MIN);
        push_item(KIND_LOAD, 1, C_MAX, C_MIN);
        push_item(KIND_LOAD, 2, C_MAX, C_MAX);
        push_item(KIND_LOAD, 3, C_MIN, C_MAX);
        program_regs(2, RAY_FAR_RESET);
        push_item(KIND_QUERY, 63, 0, 0);
        program_regs(4, RAY_FAR_RESET);
        push_item(KIND_QUERY, 0, 0, 0);
        push_item(KIND_QUERY, 0, C_MAX, 0);
        push_item(KIND_QUERY, 0, C_MIN, C_MIN);
        push_item(KIND_QUERY, 0, 0, C_MAX);
        push_item(KIND_QUERY, 0, 12000, 0);
        push_item(KIND_QUERY, 0, C_MIN, 0);
        program_regs(4, C_MIN);
        push_item(KIND_QUERY, 0, 0, 0);
        push_item(KIND_QUERY, 0, C_MAX, C_MAX);
        // triangle whose base lies on the ray
        push_item(KIND_LOAD, 0, 0, 0);
        push_item(KIND_LOAD, 1, 10, 0);
        push_item(KIND_LOAD, 63, 5, 10);
        push_item(KIND_LOAD, 2, 5, 10);
        program_regs(3, C_MAX);
        push_item(KIND_QUERY, 0, -5, 0);
        push_item(KIND_QUERY, 0, 3, 0);
        push_item(KIND_QUERY, 0, 5, 5);
        push_item(KIND_QUERY, 0, -3, 10);
        push_item(KIND_QUERY, 0, 20, 5);

        phase = 0;
        while (items_sent < ITEMS) begin
            if (phase == 0) begin
                count = 127;
            end else if (phase == 1) begin
                count = MAX_VERT;
            end else begin
                case ($urandom_range(0, 19))
                    0:       count = rnd(0, 2);
                    1:       count = rnd(MAX_VERT + 1, 127);
                    2:       count = MAX_VERT;
                    default: count = rnd(3, 12);
                endcase
            end
            nv = (count > MAX_VERT) ? MAX_VERT : count;
            nv = (nv < 3) ? 3 : nv;
            make_polygon(nv);
            case ($urandom_range(0, 5))
                0:       far = RAY_FAR_RESET;
                1:       far = C_MIN;
                2:       far = C_MAX;
                3:       far = rnd(C_MIN, C_MAX);
                default: far = clip(poly_x[rnd(0, nv - 1)] + rnd(-20, 20));
            endcase
            idling = (items_sent < ITEMS - 200) && ($urandom_range(0, 3) != 0);
            program_regs(count, far);
            for (int i = 0; i < nv; i++) begin
                push_item(KIND_LOAD, i, poly_x[i], poly_y[i]);
            end
            nq = rnd(15, 40);
            repeat (nq) begin
                if ($urandom_range(0, 9) == 0) begin
                    k = rnd(0, MAX_VERT - 1);
                    x = rnd(C_MIN, C_MAX);
                    y = rnd(C_MIN, C_MAX);
                    push_item(KIND_LOAD, k, x, y);
                    if (k < nv) begin
                        poly_x[k] = x;
                        poly_y[k] = y;
                    end
                end else begin
                    pick_point(nv, x, y);
                    push_item(KIND_QUERY, rnd(0, MAX_VERT - 1), x, y);
                end
            end
            phase++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.verdicts.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
